// File: sv/assert_macros.svh
// assertion macros shared by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// condition must hold in the same cycle as the trigger
`define ASSERT_SAME(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed");

// condition must hold in the cycle after the trigger
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(lbl, clk, rst_n, trig, cond)
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cond)

`endif

`endif

// File: sv/tsd_pkg.sv
// shared types, codes and the crc-8 step for the scratchpad decoder
`default_nettype none

package tsd_pkg;

    // scratchpad length: 8 data bytes plus the check byte
    localparam int FRAME_BYTES = 9;
    localparam int DATA_BYTES  = FRAME_BYTES - 1;

    // family codes
    localparam logic [7:0] FAM_COUNT_REMAIN = 8'h10;
    localparam logic [7:0] FAM_RES_A        = 8'h28;
    localparam logic [7:0] FAM_RES_B        = 8'h22;
    localparam logic [7:0] FAM_RES_C        = 8'hA0;
    localparam logic [7:0] FAM_HUMIDITY     = 8'hA1;
    localparam logic [7:0] FAM_LUMINOSITY   = 8'hA2;

    // resolution field codes in config byte 4
    localparam logic [7:0] RES_MASK   = 8'h60;
    localparam logic [7:0] RES_9_BIT  = 8'h00;
    localparam logic [7:0] RES_10_BIT = 8'h20;
    localparam logic [7:0] RES_11_BIT = 8'h40;

    localparam logic [7:0]  COUNT_PER_C_MARK = 8'h10;
    localparam logic [15:0] COUNT_HIGH_MASK  = 16'hFFF0;
    localparam logic [15:0] COUNT_BIAS       = 16'd12;

    localparam logic [7:0] CRC_POLY = 8'h8C;

    localparam logic [11:0] MAX_WHOLE = 12'd125;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_UNKNOWN = 3'd1,
        ST_CRC     = 3'd2,
        ST_RANGE   = 3'd3,
        ST_SHORT   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        KIND_TEMP     = 2'd0,
        KIND_HUMIDITY = 2'd1,
        KIND_LUX      = 2'd2
    } kind_t;

    // everything about a result that is settled when the last byte arrives
    typedef struct packed {
        status_t            status;
        kind_t              kind;
        logic               temp_en;
        logic [7:0]         humidity_whole;
        logic [7:0]         humidity_fraction;
        logic signed [31:0] luminosity;
    } meta_t;

    // one finished result word
    typedef struct packed {
        status_t            status;
        kind_t              kind;
        logic               is_negative;
        logic [6:0]         whole_degrees;
        logic [6:0]         hundredths;
        logic [7:0]         humidity_whole;
        logic [7:0]         humidity_fraction;
        logic signed [31:0] luminosity;
    } result_t;

    // dallas crc-8, one byte, lsb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: sv/tsd_temp_pipe.sv
// temperature scaling pipeline and result register
`default_nettype none
`include "assert_macros.svh"

module tsd_temp_pipe (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load,
    input  wire tsd_pkg::meta_t  meta,
    input  wire logic [15:0]     raw,
    input  wire logic            out_ready,
    output logic                 advance,
    output logic                 out_valid,
    output tsd_pkg::result_t     result
);
    import tsd_pkg::*;

    // ceil(2^25 / 100), exact quotient for values below 2^18
    localparam int         RECIP_SHIFT = 25;
    localparam logic [18:0] RECIP_100  = 19'd335545;

    logic         v1_reg, v2_reg, v3_reg, vout_reg;
    meta_t        meta1_reg, meta2_reg, meta3_reg;
    logic [15:0]  raw1_reg;
    logic [17:0]  mag2_reg, mag3_reg;
    logic         neg2_reg, neg3_reg;
    logic [11:0]  whole3_reg;
    result_t      result_reg;

    logic [15:0]  abs_raw;
    logic [19:0]  times25;
    logic [17:0]  mag_next;
    logic [36:0]  recip_prod;
    logic [11:0]  whole_next;
    logic [17:0]  rem_full;
    result_t      result_next;

    assign advance   = !vout_reg || out_ready;
    assign out_valid = vout_reg;
    assign result    = result_reg;

    // stage 2: magnitude of raw * 25 / 4, truncated toward zero
    always_comb
    begin
        abs_raw  = raw1_reg[15] ? 16'(-raw1_reg) : raw1_reg;
        times25  = {abs_raw, 4'b0} + {1'b0, abs_raw, 3'b0} + {4'b0, abs_raw};
        mag_next = times25[19:2];
    end

    // stage 3: whole degrees by reciprocal multiply
    assign recip_prod = 37'(mag2_reg) * 37'(RECIP_100);
    assign whole_next = recip_prod[RECIP_SHIFT +: 12];

    // output stage: hundredths and range check
    always_comb
    begin
        rem_full    = mag3_reg - (18'(whole3_reg) * 18'd100);
        result_next = '0;
        result_next.status            = meta3_reg.status;
        result_next.kind              = meta3_reg.kind;
        result_next.humidity_whole    = meta3_reg.humidity_whole;
        result_next.humidity_fraction = meta3_reg.humidity_fraction;
        result_next.luminosity        = meta3_reg.luminosity;
        if (meta3_reg.temp_en)
        begin
            if (whole3_reg > MAX_WHOLE)
            begin
                result_next.status = ST_RANGE;
            end
            else
            begin
                result_next.status        = ST_OK;
                result_next.is_negative   = neg3_reg;
                result_next.whole_degrees = whole3_reg[6:0];
                result_next.hundredths    = rem_full[6:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg   <= load;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            vout_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            meta1_reg  <= meta;
            raw1_reg   <= raw;
            meta2_reg  <= meta1_reg;
            mag2_reg   <= mag_next;
            neg2_reg   <= raw1_reg[15];
            meta3_reg  <= meta2_reg;
            mag3_reg   <= mag2_reg;
            neg3_reg   <= neg2_reg;
            whole3_reg <= whole_next;
            result_reg <= result_next;
        end
    end

    `ASSERT_SAME(a_range_fields, clk, rst_n, vout_reg, (result_reg.whole_degrees <= 7'd125) && (result_reg.hundredths <= 7'd99))
    `ASSERT_SAME(a_early_fail_zero, clk, rst_n, vout_reg && (result_reg.status == ST_SHORT || result_reg.status == ST_UNKNOWN), result_reg.kind == KIND_TEMP && result_reg.luminosity == 32'sd0)
    `ASSERT_NEXT(a_stall_holds, clk, rst_n, v1_reg && !advance, v1_reg && $stable(raw1_reg))

endmodule

`default_nettype wire

// File: sv/thermometer_scratchpad_decoder_top.sv
// top level of the 1-wire scratchpad decoder
`default_nettype none
`include "assert_macros.svh"

// 1-wire scratchpad decoder. scratchpad bytes come in on the slave stream one
// word per byte, byte 0 first, with the device family code alongside; tlast
// marks the final byte of a frame. bytes 0 to 7 are stored and run through the
// dallas crc-8 (reflected 0x8c, seed 0); byte 8 is the check byte; bytes past
// the ninth are dropped until tlast. the word carrying tlast yields exactly one
// result word on the master stream: status, kind, signed temperature split
// into whole degrees and hundredths, the humidity pair or a little-endian
// luminosity word, depending on the family code. other input words yield no
// result. rate: one input word per cycle while no finished result is held
// back by m_axis_tready; the result word passes through the frame capture
// register, the magnitude stage, the reciprocal-multiply stage and the result
// register. the pipeline is one stall domain: while a finished result
// waits on m_axis_tready the whole pipe and the input hold, otherwise input is
// taken every cycle, even while results are still in flight
module thermometer_scratchpad_decoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // data_byte [7:0], family_code [15:8]
    input  wire logic        s_axis_tlast,   // last_byte
    // master stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status [2:0], is_negative [3], whole_degrees [10:4], hundredths [17:11],
    // humidity_whole [25:18], humidity_fraction [33:26], luminosity [65:34],
    // zero [71:66]
    output logic [71:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser    // kind
);
    import tsd_pkg::*;

    localparam logic [3:0] CHECK_POS = 4'(DATA_BYTES);
    localparam logic [3:0] FULL_CNT  = 4'(FRAME_BYTES);

    // frame capture state
    logic [3:0]  byte_count_reg;
    logic [7:0]  crc_reg;
    logic [7:0]  frame_reg [DATA_BYTES];
    logic [7:0]  check_reg;

    logic        advance;
    logic        accept;
    logic        decode;
    logic [7:0]  data_byte;
    logic [7:0]  family_code;
    logic        short_frame;
    logic        family_known;
    logic        crc_ok;
    meta_t       meta;
    logic [15:0] raw;
    logic [15:0] raw_shift;
    result_t     result;

    assign data_byte     = s_axis_tdata[7:0];
    assign family_code   = s_axis_tdata[15:8];
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid && advance;
    assign decode        = accept && s_axis_tlast;

    // the frame is short unless this byte is at least the check byte
    assign short_frame = byte_count_reg < CHECK_POS;

    // check byte is either arriving now or already stored
    assign crc_ok = (byte_count_reg == CHECK_POS) ? (crc_reg == data_byte)
                                                  : (crc_reg == check_reg);

    always_comb
    begin
        case (family_code) inside
            FAM_COUNT_REMAIN, FAM_RES_A, FAM_RES_B, FAM_RES_C,
            FAM_HUMIDITY, FAM_LUMINOSITY: family_known = 1'b1;
            default:                      family_known = 1'b0;
        endcase
    end

    // classify the frame; temperature math is left to the pipe
    always_comb
    begin
        meta = '0;
        if (short_frame)
        begin
            meta.status = ST_SHORT;
        end
        else if (!family_known)
        begin
            meta.status = ST_UNKNOWN;
        end
        else
        begin
            case (family_code)
                FAM_HUMIDITY:   meta.kind = KIND_HUMIDITY;
                FAM_LUMINOSITY: meta.kind = KIND_LUX;
                default:        meta.kind = KIND_TEMP;
            endcase
            if (!crc_ok)
            begin
                meta.status = ST_CRC;
            end
            else if (family_code == FAM_LUMINOSITY)
            begin
                meta.status     = ST_OK;
                meta.luminosity = {frame_reg[3], frame_reg[2], frame_reg[1], frame_reg[0]};
            end
            else
            begin
                meta.status  = ST_OK;
                meta.temp_en = 1'b1;
                if (family_code == FAM_HUMIDITY)
                begin
                    meta.humidity_whole    = frame_reg[2];
                    meta.humidity_fraction = frame_reg[3];
                end
            end
        end
    end

    // raw 1/16 degree count per family
    always_comb
    begin
        raw       = {frame_reg[1], frame_reg[0]};
        raw_shift = {raw[12:0], 3'b0};
        case (family_code)
            FAM_COUNT_REMAIN:
            begin
                // extended resolution from count remain
                if (frame_reg[7] == COUNT_PER_C_MARK)
                begin
                    raw = (raw_shift & COUNT_HIGH_MASK) + COUNT_BIAS - {8'b0, frame_reg[6]};
                end
                else
                begin
                    raw = raw_shift;
                end
            end
            FAM_RES_A, FAM_RES_B, FAM_RES_C:
            begin
                case (frame_reg[4] & RES_MASK)
                    RES_9_BIT:  raw = raw & 16'hFFF8;
                    RES_10_BIT: raw = raw & 16'hFFFC;
                    RES_11_BIT: raw = raw & 16'hFFFE;
                    default:    raw = raw;
                endcase
            end
            default:
            begin
                raw = {frame_reg[1], frame_reg[0]};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            crc_reg        <= '0;
        end
        else if (accept)
        begin
            if (s_axis_tlast)
            begin
                byte_count_reg <= '0;
                crc_reg        <= '0;
            end
            else
            begin
                if (byte_count_reg < FULL_CNT)
                begin
                    byte_count_reg <= byte_count_reg + 4'd1;
                end
                if (byte_count_reg < CHECK_POS)
                begin
                    crc_reg <= crc8_byte(crc_reg, data_byte);
                end
            end
        end
    end

    // scratchpad storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (byte_count_reg < CHECK_POS)
            begin
                frame_reg[byte_count_reg[2:0]] <= data_byte;
            end
            else if (byte_count_reg == CHECK_POS)
            begin
                check_reg <= data_byte;
            end
        end
    end

    tsd_temp_pipe u_temp_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (decode),
        .meta      (meta),
        .raw       (raw),
        .out_ready (m_axis_tready),
        .advance   (advance),
        .out_valid (m_axis_tvalid),
        .result    (result)
    );

    assign m_axis_tuser = result.kind;
    assign m_axis_tdata = {6'b0,
                           result.luminosity,
                           result.humidity_fraction,
                           result.humidity_whole,
                           result.hundredths,
                           result.whole_degrees,
                           result.is_negative,
                           result.status};

    `ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, byte_count_reg <= FULL_CNT)
    `ASSERT_NEXT(a_frame_restart, clk, rst_n, decode, byte_count_reg == 4'd0 && crc_reg == 8'd0)
    `ASSERT_NEXT(a_count_step, clk, rst_n, accept && !s_axis_tlast && byte_count_reg < FULL_CNT, byte_count_reg == $past(byte_count_reg) + 4'd1)

endmodule

`default_nettype wire

// File: test/tb.sv
// testbench for the 1-wire scratchpad decoder: random framed byte streams checked against a predictor
`timescale 1ns / 100ps

module tb;
    import tsd_pkg::*;

    // keeps its own copy of the decoder state, predicts one reading per frame
    // and checks each result word against the oldest prediction
    class scratchpad_scoreboard;
        logic [3:0] byte_count;
        logic [7:0] crc_acc;
        logic [7:0] frame [0:7];
        logic [7:0] check_byte;
        result_t    expected_readings [$];
        int         errors;
        int         words_taken;
        int         readings_seen;
        int         status_count [0:7];

        function new();
            byte_count = '0;
            crc_acc    = '0;
            check_byte = '0;
            foreach (frame[i])
            begin
                frame[i] = '0;
            end
            foreach (status_count[i])
            begin
                status_count[i] = 0;
            end
            errors        = 0;
            words_taken   = 0;
            readings_seen = 0;
        endfunction

        // reflected crc-8, polynomial 0x8c, one byte lsb first
        static function logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
            logic [7:0] c;
            c = crc ^ b;
            for (int i = 0; i < 8; i++)
            begin
                c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
            end
            return c;
        endfunction

        // one accepted input word; a word with last queues one expected reading
        function void absorb_byte(input logic [7:0] b, input logic [7:0] fam, input logic last);
            result_t     r;
            logic [15:0] raw16;
            int          raw_i;
            int          tc;
            int          mag;
            int          whole_i;
            words_taken++;
            if (byte_count < 4'd8)
            begin
                frame[byte_count[2:0]] = b;
                crc_acc = crc_step(crc_acc, b);
            end
            else if (byte_count == 4'd8)
            begin
                check_byte = b;
            end
            if (byte_count < 4'(FRAME_BYTES))
            begin
                byte_count = byte_count + 4'd1;
            end
            if (!last)
            begin
                return;
            end
            r = '0;
            if (byte_count < 4'(FRAME_BYTES))
            begin
                r.status = ST_SHORT;
            end
            else if (fam != FAM_COUNT_REMAIN && fam != FAM_RES_A && fam != FAM_RES_B &&
                     fam != FAM_RES_C && fam != FAM_HUMIDITY && fam != FAM_LUMINOSITY)
            begin
                r.status = ST_UNKNOWN;
            end
            else
            begin
                r.kind = (fam == FAM_HUMIDITY)   ? KIND_HUMIDITY :
                         (fam == FAM_LUMINOSITY) ? KIND_LUX : KIND_TEMP;
                if (crc_acc != check_byte)
                begin
                    r.status = ST_CRC;
                end
                else if (fam == FAM_LUMINOSITY)
                begin
                    r.status     = ST_OK;
                    r.luminosity = {frame[3], frame[2], frame[1], frame[0]};
                end
                else
                begin
                    raw16 = {frame[1], frame[0]};
                    if (fam == FAM_COUNT_REMAIN)
                    begin
                        raw16 = raw16 << 3;
                        if (frame[7] == COUNT_PER_C_MARK)
                        begin
                            raw16 = (raw16 & COUNT_HIGH_MASK) + COUNT_BIAS - {8'h00, frame[6]};
                        end
                    end
                    else if (fam != FAM_HUMIDITY)
                    begin
                        case (frame[4] & RES_MASK)
                            RES_9_BIT:  raw16 = raw16 & 16'hFFF8;
                            RES_10_BIT: raw16 = raw16 & 16'hFFFC;
                            RES_11_BIT: raw16 = raw16 & 16'hFFFE;
                            default:    raw16 = raw16;
                        endcase
                    end
                    raw_i   = $signed(raw16);
                    tc      = (raw_i * 25) / 4;
                    mag     = (tc < 0) ? -tc : tc;
                    whole_i = mag / 100;
                    if (whole_i > 125)
                    begin
                        r.status = ST_RANGE;
                    end
                    else
                    begin
                        r.status        = ST_OK;
                        r.is_negative   = (tc < 0);
                        r.whole_degrees = whole_i[6:0];
                        r.hundredths    = 7'(mag % 100);
                    end
                    if (fam == FAM_HUMIDITY)
                    begin
                        r.humidity_whole    = frame[2];
                        r.humidity_fraction = frame[3];
                    end
                end
            end
            expected_readings.insert(expected_readings.size(), r);
            byte_count = '0;
            crc_acc    = '0;
        endfunction

        function void check_field(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // one accepted result word
        function void compare_reading(input logic [71:0] d, input logic [1:0] k);
            result_t want;
            if (expected_readings.size() == 0)
            begin
                $display("%0t: result word with nothing expected, expected none, actual %h/%0d",
                         $time, d, k);
                errors++;
                return;
            end
            want = expected_readings.pop_front();
            readings_seen++;
            status_count[want.status]++;
            check_field("status", want.status, d[2:0]);
            check_field("kind", want.kind, k);
            check_field("is_negative", want.is_negative, d[3]);
            check_field("whole_degrees", want.whole_degrees, d[10:4]);
            check_field("hundredths", want.hundredths, d[17:11]);
            check_field("humidity_whole", want.humidity_whole, d[25:18]);
            check_field("humidity_fraction", want.humidity_fraction, d[33:26]);
            check_field("luminosity", want.luminosity, d[65:34]);
            check_field("padding", 32'd0, d[71:66]);
        endfunction
    endclass

    // generous bound: about 1900 words, each allowed well over the slowest
    // sender gap plus receiver stall plus the four-register pipe
    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_WORDS = 1900;
    // drain allows for the pipe registers and for stalls
    localparam int DRAIN_CYCLES = 16;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;     // data_byte [7:0], family_code [15:8]
    logic        s_axis_tlast;     // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;     // status, is_negative, whole, hundredths, humidity, luminosity
    logic [1:0]  m_axis_tuser;     // kind

    scratchpad_scoreboard sb;

    // staging buffer for one frame: 8 data bytes, check byte, overrun bytes
    logic [7:0] frame_buf [0:12];

    // idling switches for each side, cleared for a long burst mid-run
    bit sender_idle;
    bit sink_idle;
    int cycle_count;
    int frames_sent;

    thermometer_scratchpad_decoder_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // watchdog: a hung pipe or a lost result word ends here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: sample the handshake at the edge, then pick next tready
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                sb.compare_reading(m_axis_tdata, m_axis_tuser);
            end
            // stall with a chance of 37 percent while idling is on
            m_axis_tready <= sink_idle ? ($urandom_range(0, 99) >= 37) : 1'b1;
        end
    end

    // one input word; valid is left high so back-to-back words never toggle it
    task automatic send_word(input logic [7:0] b, input logic [7:0] fam, input logic last);
        while (sender_idle && $urandom_range(0, 99) < 37)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {fam, b};
        s_axis_tlast  <= last;
        do
        begin
            @(posedge clk);
        end
        while (s_axis_tready !== 1'b1);
        sb.absorb_byte(b, fam, last);
    endtask

    // fill in the check byte over bytes 0..7, good or deliberately corrupted
    task automatic seal_frame(input bit crc_good);
        logic [7:0] crc;
        crc = '0;
        for (int i = 0; i < 8; i++)
        begin
            crc = scratchpad_scoreboard::crc_step(crc, frame_buf[i]);
        end
        frame_buf[8] = crc_good ? crc : (crc ^ 8'($urandom_range(1, 255)));
    endtask

    // family code matters only on the last word, so the others carry noise
    task automatic send_frame(input logic [7:0] fam, input int len);
        for (int i = 0; i < len; i++)
        begin
            send_word(frame_buf[i], (i == len - 1) ? fam : 8'($urandom), i == len - 1);
        end
        frames_sent++;
    endtask

    // temperature count, mostly across a span reaching just past the 125 degree edge, sometimes extreme
    function automatic logic [15:0] pick_raw(input logic [7:0] fam);
        int span;
        int v;
        span = (fam == FAM_COUNT_REMAIN) ? 300 : 2100;
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       return 16'h7FFF;
                    1:       return 16'h8000;
                    2:       return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            default:
            begin
                v = int'($urandom_range(0, 2 * span)) - span;
                return v[15:0];
            end
        endcase
    endfunction

    // well-formed frames with random content, plus short, overlong and
    // corrupted ones and unknown families
    task automatic random_frame();
        logic [7:0]  fam;
        logic [15:0] raw;
        int          len;
        int          pick;
        pick = $urandom_range(0, 19);
        if (pick < 3)       fam = FAM_COUNT_REMAIN;
        else if (pick < 6)  fam = FAM_RES_A;
        else if (pick < 8)  fam = FAM_RES_B;
        else if (pick < 10) fam = FAM_RES_C;
        else if (pick < 13) fam = FAM_HUMIDITY;
        else if (pick < 16) fam = FAM_LUMINOSITY;
        else                fam = 8'($urandom);
        foreach (frame_buf[i])
        begin
            frame_buf[i] = 8'($urandom);
        end
        if (fam != FAM_LUMINOSITY && $urandom_range(0, 3) != 0)
        begin
            raw          = pick_raw(fam);
            frame_buf[0] = raw[7:0];
            frame_buf[1] = raw[15:8];
        end
        if (fam == FAM_COUNT_REMAIN && $urandom_range(0, 1) == 1)
        begin
            // count-per-degree marker turns on the count-remain correction
            frame_buf[7] = COUNT_PER_C_MARK;
            frame_buf[6] = 8'($urandom_range(0, 16));
        end
        seal_frame($urandom_range(0, 9) != 0);
        pick = $urandom_range(0, 19);
        if (pick < 2)      len = $urandom_range(1, 8);
        else if (pick < 4) len = $urandom_range(10, 13);
        else               len = FRAME_BYTES;
        send_frame(fam, len);
    endtask

    task automatic wait_for_drain();
        while (sb.expected_readings.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        bit paused_mid;
        sb            = new;
        cycle_count   = 0;
        frames_sent   = 0;
        sender_idle   = 1'b1;
        sink_idle     = 1'b1;
        paused_mid    = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // short frame of a single word, all bits high
        frame_buf[0] = 8'hFF;
        send_frame(8'hFF, 1);

        // short frame one word before the check byte
        for (int i = 0; i < 8; i++)
        begin
            frame_buf[i] = 8'($urandom);
        end
        send_frame(FAM_RES_A, 8);

        // luminosity at the signed maximum
        frame_buf[0] = 8'hFF;
        frame_buf[1] = 8'hFF;
        frame_buf[2] = 8'hFF;
        frame_buf[3] = 8'h7F;
        for (int i = 4; i < 8; i++)
        begin
            frame_buf[i] = 8'h00;
        end
        seal_frame(1'b1);
        send_frame(FAM_LUMINOSITY, FRAME_BYTES);

        // most negative count: out of range, humidity pair still reported
        frame_buf[0] = 8'h00;
        frame_buf[1] = 8'h80;
        frame_buf[2] = 8'hFF;
        frame_buf[3] = 8'h00;
        for (int i = 4; i < 8; i++)
        begin
            frame_buf[i] = 8'h55;
        end
        seal_frame(1'b1);
        send_frame(FAM_HUMIDITY, FRAME_BYTES);

        // hold the sender until the pipe has emptied completely
        s_axis_tvalid <= 1'b0;
        wait_for_drain();

        while (sb.words_taken < RANDOM_WORDS)
        begin
            // long burst with both sides streaming flat out
            sender_idle = !(sb.words_taken >= 700 && sb.words_taken < 1150);
            sink_idle   = sender_idle;
            if (!paused_mid && sb.words_taken >= 1300)
            begin
                paused_mid    = 1'b1;
                s_axis_tvalid <= 1'b0;
                wait_for_drain();
            end
            random_frame();
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d input words in %0d frames and %0d result words",
                 sb.words_taken, frames_sent, sb.readings_seen);
        $display("outcomes: ok %0d, unknown family %0d, crc mismatch %0d, out of range %0d, short %0d",
                 sb.status_count[ST_OK], sb.status_count[ST_UNKNOWN], sb.status_count[ST_CRC],
                 sb.status_count[ST_RANGE], sb.status_count[ST_SHORT]);
        if (sb.errors == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
